[hw/rtl/lrt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package lrt_pkg;

  localparam int MAX_ROWS = 1024;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int LINK_W   = ROW_W + 1;
  localparam int CNT_W    = 11;
  localparam int START_W  = 10;
  localparam int CMD_W    = 3;
  localparam int STEP_W   = 10;
  localparam int STAT_W   = 2;

  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(MAX_ROWS);

  localparam logic [CMD_W-1:0] CMD_UP    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DOWN  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEL   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UNDO  = 3'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_AT_END   = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_LAST_ROW = 2'd3;

  localparam logic CFG_ROW_COUNT = 1'b0;
  localparam logic CFG_START_ROW = 1'b1;

  typedef struct packed {
    logic              init_wr;
    logic              latch_in;
    logic              link_rd;
    logic              addr_undo;
    logic              move_step;
    logic              del_commit;
    logic              undo_rd;
    logic              undo_latch;
    logic              undo_commit;
    logic              pres_rd;
    logic              set_status;
    logic [STAT_W-1:0] status_code;
    logic              out_load;
  } lrt_cmd_t;

  typedef struct packed {
    logic             init_last;
    logic [CMD_W-1:0] cmd;
    logic             steps_zero;
    logic             steps_one;
    logic             link_nil;
    logic             only_row;
    logic             depth_zero;
  } lrt_stat_t;

endpackage
`default_nettype wire

[hw/rtl/lrt_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module lrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/lrt_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module lrt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              reinit,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire lrt_pkg::lrt_stat_t st,
  output lrt_pkg::lrt_cmd_t      cmd
);
  import lrt_pkg::*;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_MRD   = 4'd3;
  localparam logic [3:0] S_MCHK  = 4'd4;
  localparam logic [3:0] S_DRD   = 4'd5;
  localparam logic [3:0] S_DCHK  = 4'd6;
  localparam logic [3:0] S_URD   = 4'd7;
  localparam logic [3:0] S_UWAIT = 4'd8;
  localparam logic [3:0] S_ULRD  = 4'd9;
  localparam logic [3:0] S_UCHK  = 4'd10;
  localparam logic [3:0] S_PRES  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (st.init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        case (st.cmd)
          CMD_UP, CMD_DOWN: state_next = st.steps_zero ? S_PRES : S_MRD;
          CMD_DEL: state_next = S_DRD;
          CMD_UNDO: begin
            if (st.depth_zero) begin
              cmd.set_status = 1'b1;
              cmd.status_code = ST_EMPTY;
              state_next = S_PRES;
            end else begin
              state_next = S_URD;
            end
          end
          default: state_next = S_PRES;
        endcase
      end
      S_MRD: begin
        cmd.link_rd = 1'b1;
        state_next = S_MCHK;
      end
      S_MCHK: begin
        if (st.link_nil) begin
          cmd.set_status = 1'b1;
          cmd.status_code = ST_AT_END;
          state_next = S_PRES;
        end else begin
          cmd.move_step = 1'b1;
          state_next = st.steps_one ? S_PRES : S_MRD;
        end
      end
      S_DRD: begin
        cmd.link_rd = 1'b1;
        state_next = S_DCHK;
      end
      S_DCHK: begin
        if (st.only_row) begin
          cmd.set_status = 1'b1;
          cmd.status_code = ST_LAST_ROW;
        end else begin
          cmd.del_commit = 1'b1;
        end
        state_next = S_PRES;
      end
      S_URD: begin
        cmd.undo_rd = 1'b1;
        state_next = S_UWAIT;
      end
      S_UWAIT: begin
        cmd.undo_latch = 1'b1;
        state_next = S_ULRD;
      end
      S_ULRD: begin
        cmd.link_rd = 1'b1;
        cmd.addr_undo = 1'b1;
        state_next = S_UCHK;
      end
      S_UCHK: begin
        cmd.undo_commit = 1'b1;
        state_next = S_PRES;
      end
      S_PRES: begin
        cmd.pres_rd = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
    if (reinit) begin
      cmd = '0;
      state_next = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/lrt_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module lrt_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [lrt_pkg::CNT_W-1:0]    cfg_data,
  input  wire logic [lrt_pkg::CMD_W-1:0]    in_cmd,
  input  wire logic [lrt_pkg::STEP_W-1:0]   in_steps,
  input  wire logic [lrt_pkg::ROW_W-1:0]    in_row,
  input  wire lrt_pkg::lrt_cmd_t            cmd,
  output lrt_pkg::lrt_stat_t                st,
  output logic [lrt_pkg::CNT_W-1:0]         depth_mon,
  output logic [lrt_pkg::ROW_W-1:0]         out_cursor,
  output logic                              out_present,
  output logic [lrt_pkg::STAT_W-1:0]        out_status
);
  import lrt_pkg::*;

  logic [CNT_W-1:0]   row_count;
  logic [START_W-1:0] start_row;
  logic [CNT_W-1:0]   n_eff;
  logic [ROW_W-1:0]   start_eff;
  logic [ROW_W-1:0]   init_cnt;
  logic [ROW_W-1:0]   cursor;
  logic [CNT_W-1:0]   depth;
  logic [CMD_W-1:0]   cmd_q;
  logic [STEP_W-1:0]  steps_q;
  logic [ROW_W-1:0]   row_q;
  logic [ROW_W-1:0]   undo_row;
  logic [STAT_W-1:0]  status_q;

  logic [LINK_W-1:0]  prev_rd, next_rd;
  logic [ROW_W-1:0]   undo_rd_data;
  logic               del_rd;
  logic [ROW_W-1:0]   link_addr;
  logic               p_nil, q_nil;
  logic [LINK_W-1:0]  init_i, init_prev, init_next;

  logic              prev_we, next_we, del_we;
  logic [ROW_W-1:0]  prev_wa, next_wa, del_wa;
  logic [LINK_W-1:0] prev_wd, next_wd;
  logic              del_wd;

  // Clamp the configured row count and start row into range.
  always_comb begin
    n_eff = row_count;
    if (row_count < CNT_W'(2)) n_eff = CNT_W'(2);
    if (row_count > CNT_W'(MAX_ROWS)) n_eff = CNT_W'(MAX_ROWS);
    start_eff = (CNT_W'(start_row) >= n_eff) ? ROW_W'(n_eff - CNT_W'(1))
                                              : ROW_W'(start_row);
  end

  assign init_i    = LINK_W'(init_cnt);
  assign init_prev = (init_cnt == '0 || CNT_W'(init_i) >= n_eff) ? NIL_LINK
                                                                 : init_i - LINK_W'(1);
  assign init_next = (CNT_W'(init_i) + CNT_W'(1) >= n_eff) ? NIL_LINK
                                                           : init_i + LINK_W'(1);

  assign p_nil = (prev_rd >= NIL_LINK);
  assign q_nil = (next_rd >= NIL_LINK);
  assign link_addr = cmd.addr_undo ? undo_row : cursor;

  // Write port selection: fill sweep, delete unlink, undo relink.
  always_comb begin
    prev_we = 1'b0; prev_wa = init_cnt; prev_wd = init_prev;
    next_we = 1'b0; next_wa = init_cnt; next_wd = init_next;
    del_we  = 1'b0; del_wa  = init_cnt; del_wd  = 1'b0;
    if (cmd.init_wr) begin
      prev_we = 1'b1; next_we = 1'b1; del_we = 1'b1;
    end else if (cmd.del_commit) begin
      prev_we = !q_nil; prev_wa = ROW_W'(next_rd); prev_wd = prev_rd;
      next_we = !p_nil; next_wa = ROW_W'(prev_rd); next_wd = next_rd;
      del_we  = 1'b1;   del_wa  = cursor;          del_wd  = 1'b1;
    end else if (cmd.undo_commit) begin
      prev_we = !q_nil; prev_wa = ROW_W'(next_rd); prev_wd = LINK_W'(undo_row);
      next_we = !p_nil; next_wa = ROW_W'(prev_rd); next_wd = LINK_W'(undo_row);
      del_we  = 1'b1;   del_wa  = undo_row;        del_wd  = 1'b0;
    end
  end

  lrt_ram #(.WIDTH(LINK_W), .DEPTH(MAX_ROWS)) u_prev (
    .clk, .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
    .rd_en(cmd.link_rd), .rd_addr(link_addr), .rd_data(prev_rd)
  );

  lrt_ram #(.WIDTH(LINK_W), .DEPTH(MAX_ROWS)) u_next (
    .clk, .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
    .rd_en(cmd.link_rd), .rd_addr(link_addr), .rd_data(next_rd)
  );

  lrt_ram #(.WIDTH(1), .DEPTH(MAX_ROWS)) u_del (
    .clk, .wr_en(del_we), .wr_addr(del_wa), .wr_data(del_wd),
    .rd_en(cmd.pres_rd), .rd_addr(row_q), .rd_data(del_rd)
  );

  lrt_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ROWS)) u_undo (
    .clk, .wr_en(cmd.del_commit), .wr_addr(depth[ROW_W-1:0]), .wr_data(cursor),
    .rd_en(cmd.undo_rd), .rd_addr(ROW_W'(depth - CNT_W'(1))), .rd_data(undo_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= CNT_W'(MAX_ROWS);
      start_row <= '0;
      init_cnt  <= '0;
      depth     <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ROW_COUNT) row_count <= cfg_data;
      else start_row <= cfg_data[START_W-1:0];
      init_cnt <= '0;
      depth    <= '0;
    end else begin
      if (cmd.init_wr) init_cnt <= init_cnt + ROW_W'(1);
      if (cmd.del_commit) depth <= depth + CNT_W'(1);
      if (cmd.undo_commit) depth <= depth - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_wr && init_cnt == ROW_W'(MAX_ROWS - 1)) cursor <= start_eff;
    if (cmd.move_step) begin
      cursor  <= ROW_W'((cmd_q == CMD_UP) ? prev_rd : next_rd);
      steps_q <= steps_q - STEP_W'(1);
    end
    if (cmd.del_commit) cursor <= q_nil ? ROW_W'(prev_rd) : ROW_W'(next_rd);
    if (cmd.latch_in) begin
      cmd_q    <= in_cmd;
      steps_q  <= in_steps;
      row_q    <= in_row;
      status_q <= ST_OK;
    end
    if (cmd.set_status) status_q <= cmd.status_code;
    if (cmd.undo_latch) undo_row <= undo_rd_data;
    if (cmd.out_load) begin
      out_cursor  <= cursor;
      out_present <= (CNT_W'(row_q) < n_eff) && !del_rd;
      out_status  <= status_q;
    end
  end

  assign st.init_last  = (init_cnt == ROW_W'(MAX_ROWS - 1));
  assign st.cmd        = cmd_q;
  assign st.steps_zero = (steps_q == '0);
  assign st.steps_one  = (steps_q == STEP_W'(1));
  assign st.link_nil   = (cmd_q == CMD_UP) ? p_nil : q_nil;
  assign st.only_row   = p_nil && q_nil;
  assign st.depth_zero = (depth == '0);
  assign depth_mon     = depth;

endmodule
`default_nettype wire

[hw/rtl/linked_row_table_with_undo_unit.sv]
// A move reads one link per step and stops at the list end; a delete reads the
//   cursor's links and commits; an undo reads the stack top, then that row's links;
//   an empty-stack undo and a query go straight to the result.
// Throughput: one request at a time; the next is taken once the result is
//   registered. Link memory read latency sets the per-step cost.
// Reset and any config write start a fill sweep through the link and
//   deleted-flag memories; no request is accepted until it ends.
`timescale 1ns / 1ps
`default_nettype none
module linked_row_table_with_undo_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [10:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata: cmd [2:0], step_count [12:3], row [22:13], zero [23]
  input  wire logic [23:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // m_tdata: cursor_row [9:0], row_present [10], status [12:11], zero [15:13]
  output logic [15:0]      m_tdata
);
  import lrt_pkg::*;

  lrt_cmd_t         cmd;
  lrt_stat_t        st;
  logic [CNT_W-1:0] depth_mon;
  logic [ROW_W-1:0] out_cursor;
  logic             out_present;
  logic [STAT_W-1:0] out_status;

  // Controller: sequences each request through memory reads and commits.
  lrt_ctrl u_ctrl (
    .clk, .rst, .reinit(cfg_we),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .st, .cmd
  );

  // Datapath: link memories, undo stack, cursor and result register.
  lrt_dp u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_cmd(s_tdata[2:0]), .in_steps(s_tdata[12:3]), .in_row(s_tdata[22:13]),
    .cmd, .st, .depth_mon,
    .out_cursor, .out_present, .out_status
  );

  assign m_tdata = {3'b000, out_status, out_present, out_cursor};

  // At most MAX_ROWS-1 rows can ever be deleted.
  a_depth: assert property (@(posedge clk) disable iff (rst)
    depth_mon < CNT_W'(MAX_ROWS))
    else $error("undo stack overflow");

  // A request is worked on alone: ready drops right after acceptance.
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while busy");

  // A config write restarts the fill sweep, blocking requests.
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !s_tready)
    else $error("request accepted during fill");

  // Delete and undo never commit together.
  a_commit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.del_commit && cmd.undo_commit))
    else $error("conflicting commits");

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import lrt_pkg::*;

  // codes the package leaves unnamed
  localparam logic [CMD_W-1:0] CMD_QUERY       = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
  localparam int CYCLE_LIMIT = 20000000;

  // Row table predictor: keeps its own links, flags, undo stack and cursor,
  // and queues the response each accepted request should produce.
  class row_table_tracker;
    logic [LINK_W-1:0] up_link[MAX_ROWS];
    logic [LINK_W-1:0] down_link[MAX_ROWS];
    bit                gone[MAX_ROWS];
    logic [ROW_W-1:0]  undo_rows[MAX_ROWS];
    int                undo_depth;
    logic [ROW_W-1:0]  cur;
    logic [CNT_W-1:0]  count_reg;
    logic [START_W-1:0] start_reg;
    logic [15:0]       pending[$];

    function int live_rows();
      int n;
      n = count_reg;
      if (n < 2) n = 2;
      if (n > MAX_ROWS) n = MAX_ROWS;
      return n;
    endfunction

    function void rebuild();
      int n;
      n = live_rows();
      for (int i = 0; i < MAX_ROWS; i++) begin
        up_link[i]   = (i == 0 || i >= n) ? NIL_LINK : LINK_W'(i - 1);
        down_link[i] = (i + 1 >= n) ? NIL_LINK : LINK_W'(i + 1);
        gone[i] = 0;
      end
      undo_depth = 0;
      cur = (start_reg >= n) ? ROW_W'(n - 1) : start_reg;
    endfunction

    function new();
      count_reg = CNT_W'(MAX_ROWS);
      start_reg = '0;
      rebuild();
    endfunction

    function void write_reg(logic idx, logic [10:0] val);
      if (idx == CFG_ROW_COUNT) count_reg = val;
      else start_reg = val[START_W-1:0];
      rebuild();
    endfunction

    function bit is_idle();
      return pending.size() == 0;
    endfunction

    // Work out the effect of one accepted request and queue its response.
    function void note_request(logic [CMD_W-1:0] op, logic [STEP_W-1:0] steps,
                               logic [ROW_W-1:0] ask);
      logic [STAT_W-1:0] st;
      logic [LINK_W-1:0] nx, p, q;
      logic [ROW_W-1:0]  r;
      bit                pres;
      st = ST_OK;
      if (op == CMD_UP || op == CMD_DOWN) begin
        for (int i = 0; i < steps; i++) begin
          nx = (op == CMD_UP) ? up_link[cur] : down_link[cur];
          if (nx >= NIL_LINK) begin
            st = ST_AT_END;
            break;
          end
          cur = nx[ROW_W-1:0];
        end
      end else if (op == CMD_DEL) begin
        p = up_link[cur];
        q = down_link[cur];
        if (p >= NIL_LINK && q >= NIL_LINK) begin
          st = ST_LAST_ROW;
        end else begin
          undo_rows[undo_depth] = cur;
          undo_depth++;
          gone[cur] = 1;
          if (p < NIL_LINK) down_link[p[ROW_W-1:0]] = q;
          if (q < NIL_LINK) up_link[q[ROW_W-1:0]] = p;
          cur = (q < NIL_LINK) ? q[ROW_W-1:0] : p[ROW_W-1:0];
        end
      end else if (op == CMD_UNDO) begin
        if (undo_depth == 0) begin
          st = ST_EMPTY;
        end else begin
          undo_depth--;
          r = undo_rows[undo_depth];
          gone[r] = 0;
          p = up_link[r];
          q = down_link[r];
          if (p < NIL_LINK) down_link[p[ROW_W-1:0]] = LINK_W'(r);
          if (q < NIL_LINK) up_link[q[ROW_W-1:0]] = LINK_W'(r);
        end
      end
      pres = (ask < live_rows()) && !gone[ask];
      pending.push_back({3'b000, st, pres, cur});
    endfunction

    // Compare one response with the oldest queued one; return a message on mismatch.
    function string check_result(logic [15:0] got);
      logic [15:0] want;
      string msg;
      if (pending.size() == 0) return $sformatf("unexpected response %h", got);
      want = pending.pop_front();
      msg = "";
      if (got[9:0] !== want[9:0])
        msg = {msg, $sformatf(" cursor_row got %0d want %0d", got[9:0], want[9:0])};
      if (got[10] !== want[10])
        msg = {msg, $sformatf(" row_present got %b want %b", got[10], want[10])};
      if (got[12:11] !== want[12:11])
        msg = {msg, $sformatf(" status got %0d want %0d", got[12:11], want[12:11])};
      if (got[15:13] !== 3'b000)
        msg = {msg, $sformatf(" pad bits got %b", got[15:13])};
      return msg;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_ROW_COUNT;
  logic [10:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // s_tdata: cmd [2:0], step_count [12:3], row [22:13], zero [23]
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // m_tdata: cursor_row [9:0], row_present [10], status [12:11], zero [15:13]
  logic [15:0] m_tdata;

  row_table_tracker table_model = new();
  int error_count = 0;
  int cycle_count = 0;

  always #2 clk = ~clk;

  linked_row_table_with_undo_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  task automatic report(string msg);
    $display("tb: mismatch at cycle %0d:%s", cycle_count, msg);
    error_count++;
  endtask

  // Watchdog: end the run as a failure once the cycle count passes CYCLE_LIMIT.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Response side: hold ready low for a random gap before each response, then take one.
  initial begin : response_sink
    int gap;
    string msg;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      msg = table_model.check_result(m_tdata);
      if (msg != "") report(msg);
    end
  end

  // Offer one request after a random gap and hold it until it is taken.
  task automatic send_request(logic [CMD_W-1:0] op, logic [STEP_W-1:0] steps,
                              logic [ROW_W-1:0] ask);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, ask, steps, op};
    do @(posedge clk); while (!s_tready);
    table_model.note_request(op, steps, ask);
  endtask

  // Lower valid and wait until every queued response has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (!table_model.is_idle()) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Write both registers while the block is idle; the fill sweep follows.
  task automatic set_table(logic [10:0] rows, logic [START_W-1:0] first);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROW_COUNT;
    cfg_data  <= rows;
    @(posedge clk);
    table_model.write_reg(CFG_ROW_COUNT, rows);
    cfg_index <= CFG_START_ROW;
    cfg_data  <= 11'(first);
    @(posedge clk);
    table_model.write_reg(CFG_START_ROW, 11'(first));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CMD_W-1:0] pick_op();
    int w;
    w = $urandom_range(0, 99);
    if (w < 25) return CMD_UP;
    if (w < 50) return CMD_DOWN;
    if (w < 72) return CMD_DEL;
    if (w < 88) return CMD_UNDO;
    if (w < 95) return CMD_QUERY;
    return 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
  endfunction

  function automatic logic [STEP_W-1:0] pick_steps();
    int w;
    w = $urandom_range(0, 99);
    if (w < 80) return STEP_W'($urandom_range(0, 15));
    if (w < 95) return STEP_W'($urandom_range(0, 1023));
    return '1;
  endfunction

  function automatic logic [ROW_W-1:0] pick_row(int n);
    if ($urandom_range(0, 3) == 0) return ROW_W'($urandom_range(0, 1023));
    return ROW_W'($urandom_range(0, n - 1));
  endfunction

  initial begin : stimulus
    logic [10:0] rows;
    logic [START_W-1:0] first;
    int n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: walk both ends of the full table, delete and undo, odd codes.
    send_request(CMD_UP, 10'd0, 10'd0);
    send_request(CMD_UP, 10'd1, 10'd1023);
    send_request(CMD_DOWN, 10'd1023, 10'd512);
    send_request(CMD_DOWN, 10'd1023, 10'd0);
    send_request(CMD_DEL, 10'd0, 10'd1023);
    send_request(CMD_UP, 10'd3, 10'd1022);
    send_request(CMD_UNDO, 10'd1023, 10'd1023);
    send_request(CMD_UNDO, 10'd0, 10'd1023);
    send_request(CMD_QUERY, 10'd0, 10'h2aa);
    send_request(CMD_SPARE_FIRST, 10'h155, 10'h155);
    send_request(CMD_SPARE_LAST, 10'h3ff, 10'h3ff);
    // Two-row table: delete until only one row is left, then undo past empty.
    set_table(11'd2, 10'd1023);
    send_request(CMD_DEL, 10'd0, 10'd1);
    send_request(CMD_DEL, 10'd0, 10'd0);
    send_request(CMD_QUERY, 10'd0, 10'd2);
    send_request(CMD_UNDO, 10'd0, 10'd1);
    send_request(CMD_UNDO, 10'd0, 10'd0);
    send_request(CMD_UP, 10'd5, 10'd1);
    // Out-of-range counts fall back to the nearest legal size.
    set_table(11'd0, 10'd0);
    send_request(CMD_DOWN, 10'd4, 10'd1);
    set_table(11'h7ff, 10'd1023);
    send_request(CMD_DOWN, 10'd1, 10'd1023);

    // Random phases over several table sizes, small ones in half of the phases.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: rows = 11'($urandom_range(2, 12));
        1: rows = 11'($urandom_range(0, 2047));
        2: rows = 11'(MAX_ROWS);
        default: rows = 11'($urandom_range(2, 64));
      endcase
      first = ($urandom_range(0, 1)) ? START_W'($urandom_range(0, 1023)) : '0;
      set_table(rows, first);
      n = table_model.live_rows();
      for (int k = 0; k < 166; k++) begin
        if (k == 83) drain();
        send_request(pick_op(), pick_steps(), pick_row(n));
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
